>>> hdl/crse_pkg.sv
// Shared types and constants for the clock ratio search encoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package crse_pkg;

  localparam int unsigned TargetW     = 16;
  localparam int unsigned RatioW      = 8;
  localparam int unsigned WordW       = 16;
  localparam int unsigned CfgIndexW   = 8;
  localparam int unsigned CfgDataW    = 8;

  localparam int unsigned SearchLimitDef = 128;
  localparam logic [RatioW-1:0] LimitReset = 8'd128;

  localparam int unsigned IdealDen = 1000;
  localparam int unsigned VcoScale = 100;
  localparam int unsigned VcoHigh  = 1200;
  localparam int unsigned VcoLow   = 600;
  localparam logic [WordW-1:0] ClkFlag = 16'h1000;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegMultLimit = 8'd0;
  localparam logic [CfgIndexW-1:0] RegDivLimit  = 8'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;     // latch target and limits, begin at d = 1, m = 2
    logic calc_dt;   // form d * target for the current divider
    logic calc_err;  // form the error of the current multiplier
    logic calc_mul;  // form both scaled distances
    logic compare;   // keep the better pair and advance the candidate
    logic finish;    // encode the best pair into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic m_last;
    logic d_last;
    logic out_free;
  } status_t;

endpackage

>>> hdl/crse_if.sv
// Valid/ready channel interfaces for the input, result and configuration transfers.
// Depends on crse_pkg for field widths.
interface crse_in_if;
  logic                              valid;
  logic                              ready;
  logic [crse_pkg::TargetW-1:0]      target_clock;
  modport source (output valid, output target_clock, input ready);
  modport sink (input valid, input target_clock, output ready);
endinterface

interface crse_out_if;
  logic                              valid;
  logic                              ready;
  logic [crse_pkg::RatioW-1:0]       multiplier;
  logic [crse_pkg::RatioW-1:0]       divider;
  logic [crse_pkg::WordW-1:0]        feedback_word;
  logic [crse_pkg::WordW-1:0]        divide_word;
  logic                              vco_out_of_range;
  modport source (output valid, output multiplier, output divider, output feedback_word,
                  output divide_word, output vco_out_of_range, input ready);
  modport sink (input valid, input multiplier, input divider, input feedback_word,
                input divide_word, input vco_out_of_range, output ready);
endinterface

interface crse_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [crse_pkg::CfgIndexW-1:0]    index;
  logic [crse_pkg::CfgDataW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/crse_ctrl.sv
// Sequencing state machine of the clock ratio search encoder.
// Depends on crse_pkg for the command and status structs.
module crse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crse_pkg::status_t status,
  output crse_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DT,
    S_ERR,
    S_MUL,
    S_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DT;
        end
      end
      S_DT: begin
        cmd.calc_dt = 1'b1;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        if (status.m_last && status.d_last) begin
          state_nxt = S_FIN;
        end else if (status.m_last) begin
          state_nxt = S_DT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

>>> hdl/crse_dp.sv
// Search datapath: candidate counters, error and distance arithmetic, best pair and output register.
// Depends on crse_pkg for widths, constants and the command and status structs.
module crse_dp #(
  parameter int unsigned SEARCH_LIMIT = crse_pkg::SearchLimitDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crse_pkg::cmd_t                cmd,
  output crse_pkg::status_t             status,
  input  logic [crse_pkg::TargetW-1:0]  target_clock,
  input  logic [crse_pkg::RatioW-1:0]   mult_limit,
  input  logic [crse_pkg::RatioW-1:0]   div_limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [crse_pkg::RatioW-1:0]   out_multiplier,
  output logic [crse_pkg::RatioW-1:0]   out_divider,
  output logic [crse_pkg::WordW-1:0]    out_feedback_word,
  output logic [crse_pkg::WordW-1:0]    out_divide_word,
  output logic                          out_vco_out_of_range
);

  localparam int unsigned RW  = crse_pkg::RatioW;
  localparam int unsigned DtW = crse_pkg::TargetW + RW;
  localparam int unsigned PrW = DtW + RW;
  localparam int unsigned VcW = RW + 11;
  localparam logic [RW:0] LimitCap = (RW+1)'(SEARCH_LIMIT);

  logic [crse_pkg::TargetW-1:0] t_r;
  logic [RW-1:0]  mmax_r, dmax_r, m_r, d_r, bm_r, bd_r;
  logic [DtW-1:0] dt_r, e_r, ebest_r;
  logic [PrW-1:0] tst_r, cur_r;
  logic           first_r, out_valid_r;

  logic [RW-1:0]  mmax_nxt, dmax_nxt, err_m;
  logic [DtW-1:0] scaled_m, e_nxt;
  logic           better;

  function automatic logic [RW-1:0] cap_limit(input logic [RW-1:0] v, input logic [RW-1:0] lo);
    logic [RW-1:0] c;
    c = ({1'b0, v} > LimitCap) ? LimitCap[RW-1:0] : v;
    return (c < lo) ? lo : c;
  endfunction

  function automatic logic [crse_pkg::WordW-1:0] count_word(input logic [RW-1:0] n);
    logic [RW-2:0] half;
    logic [RW-1:0] low;
    half = n[RW-1:1];
    low  = {1'b0, half} + {{(RW-1){1'b0}}, n[0]};
    return crse_pkg::WordW'({half, 6'b0}) | crse_pkg::WordW'(low);
  endfunction

  assign mmax_nxt = cap_limit(mult_limit, RW'(2));
  assign dmax_nxt = cap_limit(div_limit, RW'(1));

  // The error unit serves both the first multiplier of a divider and the next one after a compare.
  assign err_m    = cmd.compare ? (m_r + RW'(1)) : m_r;
  assign scaled_m = DtW'(err_m) * DtW'(crse_pkg::IdealDen);
  assign e_nxt    = (scaled_m >= dt_r) ? (scaled_m - dt_r) : (dt_r - scaled_m);

  assign better = first_r || (tst_r < cur_r);

  assign status.m_last   = (m_r == mmax_r);
  assign status.d_last   = (d_r == dmax_r);
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        first_r <= 1'b1;
      end else if (cmd.compare) begin
        first_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r    <= target_clock;
      mmax_r <= mmax_nxt;
      dmax_r <= dmax_nxt;
      m_r    <= RW'(2);
      d_r    <= RW'(1);
    end
    if (cmd.calc_dt) begin
      dt_r <= DtW'(d_r) * DtW'(t_r);
    end
    if (cmd.calc_err) begin
      e_r <= e_nxt;
    end
    if (cmd.calc_mul) begin
      tst_r <= PrW'(bd_r) * PrW'(e_r);
      cur_r <= PrW'(d_r) * PrW'(ebest_r);
    end
    if (cmd.compare) begin
      if (better) begin
        bm_r    <= m_r;
        bd_r    <= d_r;
        ebest_r <= e_r;
      end
      if (status.m_last) begin
        m_r <= RW'(2);
        d_r <= d_r + RW'(1);
      end else begin
        m_r <= m_r + RW'(1);
        e_r <= e_nxt;
      end
    end
    if (cmd.finish) begin
      out_multiplier       <= bm_r;
      out_divider          <= bd_r;
      out_feedback_word    <= crse_pkg::ClkFlag | count_word(bm_r);
      out_divide_word      <= (bd_r == RW'(1)) ? crse_pkg::ClkFlag : count_word(bd_r);
      // floor(100m/d) > 1200 exactly when 100m >= 1201d; below 600 when 100m < 600d.
      out_vco_out_of_range <=
        ((VcW'(bm_r) * VcW'(crse_pkg::VcoScale)) >= (VcW'(bd_r) * VcW'(crse_pkg::VcoHigh + 1))) ||
        ((VcW'(bm_r) * VcW'(crse_pkg::VcoScale)) <  (VcW'(bd_r) * VcW'(crse_pkg::VcoLow)));
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/clock_ratio_search_encoder_core.sv
// Top level of the clock ratio search encoder: configuration registers, controller and datapath.
// Depends on crse_pkg, the channel interfaces in crse_if, crse_ctrl and crse_dp.
//
// For each target pixel clock T (in 10 kHz units) taken in on the input channel, the block
// searches every divider d from 1 to the divider limit and, for each d, every multiplier m from
// 2 to the multiplier limit, and keeps the pair whose ratio m/d lies closest to T/1000. Distances
// are compared exactly by cross-multiplication, and a later pair wins only if it is strictly
// closer, so ties keep the pair found first. Both limits are capped at SEARCH_LIMIT and floored
// at 2 and 1 respectively. One result is delivered per input: m, d, the feedback and divide
// register words of the clock divider, and a flag set when floor(100*m/d) lies outside 600 to
// 1200. The multiplier and divider limits reset to 128, the default SEARCH_LIMIT. At each new
// divider, d * T is formed first and then the error of the first multiplier. For each
// candidate, the pair of products is formed, then the compare is made while the shared error
// unit forms the error of the next multiplier, if any. One item is searched at a time; the next
// input is taken as soon as the previous result has been moved into the output register, even
// while that result still waits for its transfer. Configuration writes are always accepted and
// take effect for the next input; they are to be made only while the block is idle. Writes to
// an unknown register index are ignored.
module clock_ratio_search_encoder_core #(
  parameter int unsigned SEARCH_LIMIT = crse_pkg::SearchLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  crse_in_if.sink     in_ch,
  crse_out_if.source  out_ch,
  crse_cfg_if.sink    cfg_ch
);

  logic [crse_pkg::RatioW-1:0] mult_limit_r;
  logic [crse_pkg::RatioW-1:0] div_limit_r;

  crse_pkg::cmd_t    cmd;
  crse_pkg::status_t status;

  // Configuration registers: a write lands on the transfer edge; the channel never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_limit_r <= crse_pkg::LimitReset;
      div_limit_r  <= crse_pkg::LimitReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        crse_pkg::RegMultLimit: mult_limit_r <= cfg_ch.data;
        crse_pkg::RegDivLimit:  div_limit_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  crse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  crse_dp #(
    .SEARCH_LIMIT (SEARCH_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .target_clock         (in_ch.target_clock),
    .mult_limit           (mult_limit_r),
    .div_limit            (div_limit_r),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_multiplier       (out_ch.multiplier),
    .out_divider          (out_ch.divider),
    .out_feedback_word    (out_ch.feedback_word),
    .out_divide_word      (out_ch.divide_word),
    .out_vco_out_of_range (out_ch.vco_out_of_range)
  );

endmodule
